// ----- hdl/ssd_pkg.sv -----
// Shared constants and types for the sensor sentence deframer.
package ssd_pkg;

   // Sentence limits
   localparam int TYPE_LEN = 2;
   localparam int DATA_LEN = 128;

   // Width of the type character counter, able to hold TYPE_LEN itself
   localparam int TYPE_CNT_W = $clog2(TYPE_LEN + 1);

   // Framing characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_FAIL  = 8'hFF;

   // Payload field types
   typedef logic [7:0]  byte_type;
   typedef logic [6:0]  index_type;
   typedef logic [7:0]  count_type;
   typedef logic [15:0] type_chars_type;
   typedef logic [1:0]  type_len_type;

endpackage

// ----- hdl/ssd_req_if.sv -----
// Request channel carrying one received serial byte.
interface ssd_req_if import ssd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/ssd_rsp_if.sv -----
// Response channel carrying one stored data byte and sentence status.
interface ssd_rsp_if import ssd_pkg::*; ();
   logic           valid;
   logic           ready;
   byte_type       data_byte;
   index_type      byte_index;
   logic           frame_done;
   count_type      data_len;
   type_chars_type type_chars;
   type_len_type   type_len;

   modport source (output valid, output data_byte, output byte_index, output frame_done,
                   output data_len, output type_chars, output type_len, input ready);
   modport sink   (input valid, input data_byte, input byte_index, input frame_done,
                   input data_len, input type_chars, input type_len, output ready);
endinterface

// ----- hdl/sensor_sentence_deframer_unit.sv -----
// Deframer for ':' TYPE ',' DATA CR LF sentences, one byte per request.
//
// Channels: req_chan takes one received byte per request; rsp_chan gives
// one response for each stored data byte (CR and LF included) with its
// index, the type characters and, on the completing LF, frame_done and
// the sentence length. Spaces, colons, type bytes and dropped bytes give
// no response.
// Path: an accepted byte is held in the input register, parsed
// combinationally, and its response is held in the response register
// until rsp_chan takes it.
// Throughput: one request per cycle while rsp_chan does not stall, set
// by the single parse stage between the input and response registers.
// Reset: synchronous; clears the parser to idle, the counters and type
// store, the halt flag and both valid flags.
// Stall: while the response register holds an untaken response the parse
// stage waits; one more byte sits in the input register, after which
// req_chan.ready falls until rsp_chan.ready returns.
// A 0xFF byte halts the parser: later bytes are taken and dropped until
// reset.
module sensor_sentence_deframer_unit import ssd_pkg::*; (
   input logic    clock,
   input logic    reset,
   ssd_req_if.sink   req_chan,
   ssd_rsp_if.source rsp_chan
);

   // Parser phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_LF   = 2'd3;

   // Input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;

   // Parser state
   logic [1:0]            phase_ff, phase_in;
   count_type             char_count_ff, char_count_in;
   type_chars_type        type_store_ff, type_store_in;
   logic [TYPE_CNT_W-1:0] type_count_ff, type_count_in;
   logic                  halted_ff, halted_in;

   // Response register
   logic           out_valid_ff, out_valid_in;
   byte_type       out_byte_ff, out_byte_in;
   index_type      out_index_ff, out_index_in;
   logic           out_done_ff, out_done_in;
   count_type      out_len_ff, out_len_in;
   type_chars_type out_chars_ff, out_chars_in;
   type_len_type   out_tlen_ff, out_tlen_in;

   logic out_free;
   logic parse_go;
   logic emit;
   logic emit_done;

   // Handshake control
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign parse_go       = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   // Advance the input register
   always_comb begin
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (parse_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Parse one byte
   always_comb begin
      phase_in      = phase_ff;
      char_count_in = char_count_ff;
      type_store_in = type_store_ff;
      type_count_in = type_count_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      emit_done     = 1'b0;
      if (parse_go && !halted_ff) begin
         if (in_byte_ff == CHAR_FAIL) begin
            halted_in = 1'b1;
         end else if (in_byte_ff == CHAR_SPACE) begin
            // drop spaces
         end else if (in_byte_ff == CHAR_COLON) begin
            phase_in      = PH_TYPE;
            char_count_in = '0;
            type_store_in = '0;
            type_count_in = '0;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  if (in_byte_ff == CHAR_COMMA) begin
                     phase_in      = PH_DATA;
                     char_count_in = '0;
                  end else if (32'(type_count_ff) < TYPE_LEN) begin
                     if (32'(type_count_ff) < 2) begin
                        if (type_count_ff[0]) begin
                           type_store_in[15:8] = in_byte_ff;
                        end else begin
                           type_store_in[7:0] = in_byte_ff;
                        end
                     end
                     type_count_in = type_count_ff + 1'b1;
                  end else begin
                     phase_in      = PH_IDLE;
                     char_count_in = '0;
                  end
               end
               PH_DATA: begin
                  if (32'(char_count_ff) >= DATA_LEN) begin
                     phase_in      = PH_IDLE;
                     char_count_in = '0;
                  end else begin
                     emit          = 1'b1;
                     char_count_in = char_count_ff + 1'b1;
                     if (in_byte_ff == CHAR_CR) begin
                        phase_in = PH_LF;
                     end
                  end
               end
               PH_LF: begin
                  if (in_byte_ff == CHAR_LF && 32'(char_count_ff) < DATA_LEN) begin
                     emit      = 1'b1;
                     emit_done = 1'b1;
                  end
                  phase_in      = PH_IDLE;
                  char_count_in = '0;
               end
               default: begin
                  // idle: drop the byte
               end
            endcase
         end
      end
   end

   // Build the response
   always_comb begin
      out_byte_in  = in_byte_ff;
      out_index_in = char_count_ff[6:0];
      out_done_in  = emit_done;
      out_len_in   = emit_done ? count_type'(char_count_ff + 1'b1) : '0;
      out_chars_in = type_store_ff;
      out_tlen_in  = (32'(type_count_ff) > 3) ? 2'd3 : type_len_type'(type_count_ff);
      if (parse_go && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         char_count_ff <= '0;
         type_store_ff <= '0;
         type_count_ff <= '0;
         halted_ff     <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         char_count_ff <= char_count_in;
         type_store_ff <= type_store_in;
         type_count_ff <= type_count_in;
         halted_ff     <= halted_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (parse_go && emit) begin
         out_byte_ff  <= out_byte_in;
         out_index_ff <= out_index_in;
         out_done_ff  <= out_done_in;
         out_len_ff   <= out_len_in;
         out_chars_ff <= out_chars_in;
         out_tlen_ff  <= out_tlen_in;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.data_byte  = out_byte_ff;
   assign rsp_chan.byte_index = out_index_ff;
   assign rsp_chan.frame_done = out_done_ff;
   assign rsp_chan.data_len   = out_len_ff;
   assign rsp_chan.type_chars = out_chars_ff;
   assign rsp_chan.type_len   = out_tlen_ff;

   // Once halted, stay halted until reset
   assert property (@(posedge clock) disable iff (reset) halted_ff |=> halted_ff)
      else $error("parser left halt without reset");

   // A halted parser produces no new response
   assert property (@(posedge clock) disable iff (reset)
      halted_ff && !out_valid_ff |=> !out_valid_ff)
      else $error("response produced while halted");

   // A completed sentence ends on LF and its length follows its index
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_done_ff |->
         out_byte_ff == CHAR_LF && out_len_ff == count_type'({1'b0, out_index_ff} + 8'd1))
      else $error("completion response inconsistent");

endmodule
